/* rtl/midi_hb_pkg.sv */
// ----------------------------------------------------------------------------
// midi_hb_pkg
// Types and constants shared by the MIDI heartbeat assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package midi_hb_pkg;

  // Operation codes carried in the op field of an input item.
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // USB MIDI code index for polyphonic aftertouch, and the chain markers.
  localparam logic [7:0] HDR_AFTERTOUCH = 8'h0A;
  localparam logic [7:0] MARK_0         = 8'hA0;
  localparam logic [7:0] MARK_1         = 8'hA1;
  localparam logic [7:0] MARK_2         = 8'hA2;

  localparam int unsigned PieceShift   = 7;
  localparam int unsigned CollectWidth = 43;
  localparam int unsigned BeatWidth    = 64;

  typedef enum logic [2:0] {
    STEP_0 = 3'b001,
    STEP_1 = 3'b010,
    STEP_2 = 3'b100
  } chain_step_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] frame_header;
    logic [7:0] frame_status;
    logic [7:0] frame_high_part;
    logic [7:0] frame_low_part;
  } in_t;

  typedef struct packed {
    logic                 first_traffic;
    logic                 traffic_seen;
    logic                 beat_valid;
    logic [BeatWidth-1:0] beat_value;
  } out_t;

endpackage

`default_nettype wire

/* rtl/midi_heartbeat_assembler_core.sv */
// ----------------------------------------------------------------------------
// midi_heartbeat_assembler_core
// Assembles heartbeat values from aftertouch frames and reports traffic.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while it is not stalled and returns
// exactly one result per item through a registered output buffer.
// Each item is handled in a single pass: the chain step, the 43-bit collector
// and the 64-bit sum of collector and local counter are all evaluated in the
// cycle of the transfer and the result is written to an output register. A
// second output entry catches one result while the output is stalled, so the
// input keeps taking items until both entries are full.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_heartbeat_assembler_core
  import midi_hb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,

  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,

  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  // State.
  chain_step_e             step_q, step_d;
  logic [CollectWidth-1:0] collected_q, collected_d;
  logic [BeatWidth-1:0]    pending_q, pending_d;
  logic                    beat_pending_q, beat_pending_d;
  logic                    traffic_q, traffic_d;
  logic [BeatWidth-1:0]    count_q, count_d;
  logic                    seen_any_q, seen_any_d;

  // Output buffer: main register and skid entry.
  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  out_t out_q, out_d;
  out_t skid_q, skid_d;

  out_t                    res;
  logic                    in_xfer;
  logic                    out_xfer;
  logic [CollectWidth-1:0] piece0, piece1, piece2, full;

  assign in_stall_o  = skid_valid_q;
  assign in_xfer     = in_valid_i && !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_xfer    = out_valid_q && !out_stall_i;

  // Pieces keep all eight bits of each byte, clipped to the collector width.
  assign piece0 = CollectWidth'(in_data_i.frame_low_part)
                | (CollectWidth'(in_data_i.frame_high_part) << PieceShift);
  assign piece1 = (CollectWidth'(in_data_i.frame_low_part) << (2 * PieceShift))
                | (CollectWidth'(in_data_i.frame_high_part) << (3 * PieceShift));
  assign piece2 = (CollectWidth'(in_data_i.frame_low_part) << (4 * PieceShift))
                | (CollectWidth'(in_data_i.frame_high_part) << (5 * PieceShift));
  assign full   = collected_q | piece2;

  always_comb begin
    res            = '0;
    step_d         = step_q;
    collected_d    = collected_q;
    pending_d      = pending_q;
    beat_pending_d = beat_pending_q;
    traffic_d      = traffic_q;
    count_d        = count_q;
    seen_any_d     = seen_any_q;
    case (in_data_i.op)
      OP_FRAME: begin
        traffic_d         = 1'b1;
        res.first_traffic = !seen_any_q;
        seen_any_d        = 1'b1;
        if (in_data_i.frame_header == HDR_AFTERTOUCH) begin
          case (step_q)
            STEP_0: begin
              if (in_data_i.frame_status == MARK_0) begin
                collected_d = piece0;
                step_d      = STEP_1;
              end
            end
            STEP_1: begin
              if (in_data_i.frame_status == MARK_1) begin
                collected_d = collected_q | piece1;
                step_d      = STEP_2;
              end else begin
                step_d = STEP_0;
              end
            end
            STEP_2: begin
              if (in_data_i.frame_status == MARK_2 && !beat_pending_q) begin
                collected_d    = full;
                pending_d      = BeatWidth'(full) + count_q;
                count_d        = count_q + BeatWidth'(1);
                beat_pending_d = 1'b1;
              end
              step_d = STEP_0;
            end
            default: step_d = STEP_0;
          endcase
        end
      end
      OP_TICK: begin
        res.traffic_seen = traffic_q;
        traffic_d        = 1'b0;
        if (beat_pending_q) begin
          res.beat_valid = 1'b1;
          res.beat_value = pending_q;
          beat_pending_d = 1'b0;
        end
      end
      OP_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  // Output buffer control. The skid entry fills only while the main register
  // holds a stalled result, and drains into it at the next output transfer.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_xfer) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (in_xfer) begin
        out_d = res;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (in_xfer) begin
      if (out_valid_q) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end else begin
        out_d       = res;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q         <= STEP_0;
      collected_q    <= '0;
      pending_q      <= '0;
      beat_pending_q <= 1'b0;
      traffic_q      <= 1'b0;
      count_q        <= '0;
      seen_any_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      skid_valid_q   <= 1'b0;
    end else begin
      if (in_xfer) begin
        step_q         <= step_d;
        collected_q    <= collected_d;
        pending_q      <= pending_d;
        beat_pending_q <= beat_pending_d;
        traffic_q      <= traffic_d;
        count_q        <= count_d;
        seen_any_q     <= seen_any_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // The skid entry is only ever occupied behind a waiting main result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without a main result");

  // A result never carries both a first-traffic report and tick fields (traffic seen or a heartbeat).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.first_traffic && (out_q.beat_valid || out_q.traffic_seen)))
    else $error("frame and tick fields mixed in one result");

  // A heartbeat value is zero unless it is flagged valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.beat_valid) |-> (out_q.beat_value == '0))
    else $error("heartbeat value without valid flag");

  // A tick transfer always leaves no heartbeat pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.op == OP_TICK) |=> !beat_pending_q)
    else $error("heartbeat still pending after tick");

  // The local counter only steps by one or returns to zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + BeatWidth'(1) || count_q == '0))
    else $error("local counter jumped");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the MIDI heartbeat assembler core. Frames, ticks
// and counter clears go in through the valid/stall input channel. A built-in
// predictor computes each expected report, and every output transfer is
// compared field by field against the oldest pending report.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import midi_hb_pkg::*;

  localparam int unsigned RandomItems = 1300;
  localparam int unsigned CycleLimit  = 400000;

  // The one op value that the block defines no action for.
  localparam logic [1:0] OpUnknown = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  midi_heartbeat_assembler_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Predicted state of the assembler.
  chain_step_e                pred_step;
  logic [CollectWidth-1:0]    pred_collect;
  logic [BeatWidth-1:0]       pred_beat;
  logic                       pred_beat_armed;
  logic                       pred_traffic;
  logic [BeatWidth-1:0]       pred_count;
  logic                       pred_seen_frame;

  out_t expected_reports[$];
  int   mismatches;
  bit   send_idle;
  bit   recv_idle;
  int   hold_off_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [CollectWidth-1:0] piece_bits(logic [7:0] hi, logic [7:0] lo,
                                                         int unsigned k);
    logic [63:0]  wide;
    int unsigned  sh;
    sh   = 2 * PieceShift * k;
    wide = (64'(lo) << sh) | (64'(hi) << (sh + PieceShift));
    return wide[CollectWidth-1:0];
  endfunction

  function automatic out_t predict_report(in_t item);
    out_t res;
    res = '0;
    case (item.op)
      OP_FRAME: begin
        res.first_traffic = !pred_seen_frame;
        pred_seen_frame   = 1'b1;
        pred_traffic      = 1'b1;
        if (item.frame_header == HDR_AFTERTOUCH) begin
          case (pred_step)
            STEP_0: begin
              if (item.frame_status == MARK_0) begin
                pred_collect = piece_bits(item.frame_high_part, item.frame_low_part, 0);
                pred_step    = STEP_1;
              end
            end
            STEP_1: begin
              if (item.frame_status == MARK_1) begin
                pred_collect |= piece_bits(item.frame_high_part, item.frame_low_part, 1);
                pred_step     = STEP_2;
              end else begin
                pred_step = STEP_0;
              end
            end
            STEP_2: begin
              // A completed chain is dropped while an earlier beat waits for a tick.
              if (item.frame_status == MARK_2 && !pred_beat_armed) begin
                pred_collect   |= piece_bits(item.frame_high_part, item.frame_low_part, 2);
                pred_beat       = BeatWidth'(pred_collect) + pred_count;
                pred_count      = pred_count + BeatWidth'(1);
                pred_beat_armed = 1'b1;
              end
              pred_step = STEP_0;
            end
            default: pred_step = STEP_0;
          endcase
        end
      end
      OP_TICK: begin
        res.traffic_seen = pred_traffic;
        pred_traffic     = 1'b0;
        if (pred_beat_armed) begin
          res.beat_valid  = 1'b1;
          res.beat_value  = pred_beat;
          pred_beat_armed = 1'b0;
        end
      end
      OP_CLEAR: pred_count = '0;
      default: ;
    endcase
    return res;
  endfunction

  task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Output transfers are checked before the input transfer of the same edge is
  // predicted; a result never leaves in the cycle its item is taken.
  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual %h", $time, out_data_o);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("first_traffic", 64'(want.first_traffic), 64'(out_data_o.first_traffic));
          compare_field("traffic_seen", 64'(want.traffic_seen), 64'(out_data_o.traffic_seen));
          compare_field("beat_valid", 64'(want.beat_valid), 64'(out_data_o.beat_valid));
          compare_field("beat_value", want.beat_value, out_data_o.beat_value);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        expected_reports.push_back(predict_report(in_data_i));
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: a random stall before each transfer while recv_idle is set, plus any
  // long hold-off that a test asks for.
  initial begin : receiver
    int stall_len;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall_len       = (recv_idle ? $urandom_range(0, 5) : 0) + hold_off_cycles;
      hold_off_cycles = 0;
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_item(in_t item);
    int gap;
    gap = send_idle ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_frame(logic [7:0] hdr, logic [7:0] status, logic [7:0] hi,
                            logic [7:0] lo);
    in_t item;
    item.op              = OP_FRAME;
    item.frame_header    = hdr;
    item.frame_status    = status;
    item.frame_high_part = hi;
    item.frame_low_part  = lo;
    send_item(item);
  endtask

  // Non-frame items carry random bytes, which the block must ignore.
  task automatic send_op(logic [1:0] op);
    logic [63:0] raw;
    in_t         item;
    raw     = {$urandom(), $urandom()};
    item    = raw[$bits(in_t)-1:0];
    item.op = op;
    send_item(item);
  endtask

  task automatic send_chain(logic [7:0] hi, logic [7:0] lo);
    send_frame(HDR_AFTERTOUCH, MARK_0, hi, lo);
    send_frame(HDR_AFTERTOUCH, MARK_1, hi, lo);
    send_frame(HDR_AFTERTOUCH, MARK_2, hi, lo);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_reports.size() != 0);
  endtask

  task automatic test_traffic_flags();
    send_op(OP_TICK);
    send_frame(8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(8'hFF, MARK_0, 8'hFF, 8'hFF);
    send_op(OP_TICK);
    send_op(OP_TICK);
  endtask

  task automatic test_chain_extremes();
    send_chain(8'hFF, 8'hFF);
    send_op(OP_TICK);
  endtask

  task automatic test_chain_breaks();
    send_frame(HDR_AFTERTOUCH, MARK_1, 8'h12, 8'h34);
    send_frame(HDR_AFTERTOUCH, MARK_0, 8'h55, 8'hAA);
    send_frame(HDR_AFTERTOUCH, MARK_2, 8'h55, 8'hAA);
    send_frame(HDR_AFTERTOUCH, MARK_0, 8'h01, 8'h80);
    send_frame(HDR_AFTERTOUCH, MARK_1, 8'h7F, 8'h7F);
    send_frame(HDR_AFTERTOUCH, MARK_1, 8'h7F, 8'h7F);
    send_chain(8'h00, 8'h00);
    // The second chain completes while a beat is still pending.
    send_chain(8'hC3, 8'h3C);
    send_op(OP_TICK);
  endtask

  task automatic test_counter_ops();
    send_op(OP_CLEAR);
    send_op(OpUnknown);
    send_op(OP_TICK);
  endtask

  task automatic test_output_backpressure();
    send_idle       = 1'b0;
    recv_idle       = 1'b0;
    hold_off_cycles = 40;
    repeat (5) begin
      send_chain(8'($urandom), 8'($urandom));
      send_op(OP_TICK);
    end
  endtask

  task automatic test_drain_pause();
    wait_drained();
    send_chain(8'($urandom), 8'($urandom));
    send_op(OP_TICK);
  endtask

  task automatic test_random_traffic();
    int         sent;
    int         pick;
    logic [7:0] status;
    logic [7:0] hdr;
    sent = 0;
    while (sent < RandomItems) begin
      if ($urandom_range(0, 31) == 0) begin
        send_idle = $urandom_range(0, 2) != 0;
        recv_idle = $urandom_range(0, 2) != 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // Mostly clean chains; now and then a wrong marker or a foreign header.
        for (int k = 0; k < 3; k++) begin
          status = MARK_0 + 8'(k);
          hdr    = HDR_AFTERTOUCH;
          if ($urandom_range(0, 11) == 0) status = 8'($urandom);
          if ($urandom_range(0, 11) == 0) hdr = 8'($urandom);
          send_frame(hdr, status, 8'($urandom), 8'($urandom));
        end
        sent += 3;
      end else if (pick < 80) begin
        send_op(OP_TICK);
        sent++;
      end else if (pick < 84) begin
        send_op(OP_CLEAR);
        sent++;
      end else if (pick < 88) begin
        send_op(OpUnknown);
        sent++;
      end else begin
        hdr = ($urandom_range(0, 1) != 0) ? HDR_AFTERTOUCH : 8'($urandom);
        send_frame(hdr, 8'($urandom), 8'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    mismatches      = 0;
    send_idle       = 1'b1;
    recv_idle       = 1'b1;
    hold_off_cycles = 0;
    pred_step       = STEP_0;
    pred_collect    = '0;
    pred_beat       = '0;
    pred_beat_armed = 1'b0;
    pred_traffic    = 1'b0;
    pred_count      = '0;
    pred_seen_frame = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_traffic_flags();
    test_chain_extremes();
    test_chain_breaks();
    test_counter_ops();
    test_output_backpressure();
    test_drain_pause();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    test_random_traffic();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
